>>> hw/rtl/lzx_pkg.sv
package lzx_pkg;

   localparam int unsigned WindowSizeDefault     = 32768;
   localparam int unsigned BytesPerResultDefault = 8;
   localparam int unsigned MaxMatchLength        = 383;
   localparam int unsigned MaxResults            = 48;

   localparam int unsigned LenWidth   = 9;
   localparam int unsigned DistWidth  = 16;
   localparam int unsigned OutWidth   = 64;
   localparam int unsigned CountWidth = 4;

   localparam logic KindLiteral = 1'b0;
   localparam logic KindMatch   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture the accepted item
      logic rd_issue;  // present source address to memory
      logic copy;      // take read byte, write it, pack it
      logic emit;      // move packed word into output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_literal;
      logic is_empty;   // match of length zero
      logic word_full;  // word holds a full set of bytes or run is done
      logic run_done;   // no bytes left to copy
      logic out_busy;   // output register still holds an item
   } status_type;

endpackage

>>> hw/rtl/lzx_stream_if.sv
interface lzx_stream_if #(
   parameter int unsigned Width = 8
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/lzx_ram.sv
module lzx_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/lzx_ctrl.sv
module lzx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lzx_pkg::status_type   status,
   output lzx_pkg::cmd_type      cmd
);
   lzx_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzx_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lzx_pkg::ST_READ;
            end
         end
         lzx_pkg::ST_READ: begin
            if (status.is_literal) begin
               state_in = lzx_pkg::ST_EMIT;
            end else if (status.is_empty) begin
               state_in = lzx_pkg::ST_IDLE;
            end else begin
               state_in = lzx_pkg::ST_COPY;
            end
         end
         lzx_pkg::ST_COPY: begin
            if (status.word_full) begin
               state_in = lzx_pkg::ST_EMIT;
            end else begin
               state_in = lzx_pkg::ST_READ;
            end
         end
         lzx_pkg::ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = status.run_done ? lzx_pkg::ST_IDLE : lzx_pkg::ST_READ;
            end
         end
         default: state_in = lzx_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lzx_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lzx_pkg::ST_READ: begin
            cmd.rd_issue = 1'b1;
         end
         lzx_pkg::ST_COPY: begin
            cmd.copy = 1'b1;
         end
         lzx_pkg::ST_EMIT: begin
            cmd.emit = !status.out_busy;
         end
         default: cmd = '0;
      endcase
   end
endmodule

>>> hw/rtl/lzx_datapath.sv
module lzx_datapath #(
   parameter int unsigned WindowSize     = lzx_pkg::WindowSizeDefault,
   parameter int unsigned BytesPerResult = lzx_pkg::BytesPerResultDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_kind,
   input  logic [7:0]                         req_literal,
   input  logic [lzx_pkg::LenWidth-1:0]       req_match_length,
   input  logic [lzx_pkg::DistWidth-1:0]      req_match_distance,
   input  lzx_pkg::cmd_type                   cmd,
   output lzx_pkg::status_type                status,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lzx_pkg::OutWidth-1:0]       rsp_out_bytes,
   output logic [lzx_pkg::CountWidth-1:0]     rsp_byte_count,
   output logic                               rsp_last
);
   localparam int unsigned AddrWidth = $clog2(WindowSize);
   localparam int unsigned FillWidth = $clog2(BytesPerResult + 1);
   localparam int unsigned ByCount   = lzx_pkg::MaxResults * BytesPerResult;
   localparam int unsigned LenCap    = (ByCount < lzx_pkg::MaxMatchLength)
                                       ? ByCount : lzx_pkg::MaxMatchLength;

   logic [AddrWidth-1:0]           wpos_ff, wpos_in;
   logic [AddrWidth-1:0]           src_ff, src_in;
   logic [lzx_pkg::LenWidth-1:0]   remain_ff, remain_in;
   logic                           literal_ff, literal_in;
   logic [7:0]                     lit_ff, lit_in;
   logic [lzx_pkg::OutWidth-1:0]   word_ff, word_in;
   logic [FillWidth-1:0]           fill_ff, fill_in;
   logic                           ovalid_ff, ovalid_in;
   logic [lzx_pkg::OutWidth-1:0]   obytes_ff, obytes_in;
   logic [lzx_pkg::CountWidth-1:0] ocount_ff, ocount_in;
   logic                           olast_ff, olast_in;

   logic                           wr_en;
   logic [7:0]                     wr_data, rd_data;
   logic [lzx_pkg::LenWidth-1:0]   len_sat;
   logic [AddrWidth-1:0]           dist_mod;

   lzx_ram #(.Width(8), .Depth(WindowSize)) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wpos_ff),
      .wr_data (wr_data),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   // window size is a power of two, so modulo is a truncation
   assign dist_mod = req_match_distance[AddrWidth-1:0];
   assign len_sat  = (req_match_length > lzx_pkg::LenWidth'(LenCap))
                     ? lzx_pkg::LenWidth'(LenCap) : req_match_length;

   // literal is written on emit; copy bytes are written as they arrive
   assign wr_en   = (cmd.copy) || (cmd.emit && literal_ff);
   assign wr_data = cmd.copy ? rd_data : lit_ff;

   always_comb begin
      wpos_in    = wpos_ff;
      src_in     = src_ff;
      remain_in  = remain_ff;
      literal_in = literal_ff;
      lit_in     = lit_ff;
      word_in    = word_ff;
      fill_in    = fill_ff;
      ovalid_in  = ovalid_ff;
      obytes_in  = obytes_ff;
      ocount_in  = ocount_ff;
      olast_in   = olast_ff;

      if (ovalid_ff && rsp_ready) begin
         ovalid_in = 1'b0;
      end

      if (cmd.load) begin
         literal_in = (req_kind == lzx_pkg::KindLiteral);
         lit_in     = req_literal;
         remain_in  = (req_kind == lzx_pkg::KindLiteral) ? '0 : len_sat;
         src_in     = wpos_ff - dist_mod;
         word_in    = '0;
         fill_in    = '0;
      end

      if (cmd.copy) begin
         word_in[8*fill_ff +: 8] = rd_data;
         fill_in   = fill_ff + 1'b1;
         remain_in = remain_ff - 1'b1;
         src_in    = src_ff + 1'b1;
         wpos_in   = wpos_ff + 1'b1;
      end

      if (cmd.emit) begin
         ovalid_in = 1'b1;
         olast_in  = (remain_ff == '0);
         if (literal_ff) begin
            obytes_in = lzx_pkg::OutWidth'(lit_ff);
            ocount_in = lzx_pkg::CountWidth'(1);
            wpos_in   = wpos_ff + 1'b1;
         end else begin
            obytes_in = word_ff;
            ocount_in = lzx_pkg::CountWidth'(fill_ff);
         end
         word_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         wpos_ff   <= wpos_in;
         ovalid_ff <= ovalid_in;
      end
      src_ff     <= src_in;
      remain_ff  <= remain_in;
      literal_ff <= literal_in;
      lit_ff     <= lit_in;
      word_ff    <= word_in;
      fill_ff    <= fill_in;
      obytes_ff  <= obytes_in;
      ocount_ff  <= ocount_in;
      olast_ff   <= olast_in;
   end

   assign status.is_literal = literal_ff;
   assign status.is_empty   = (remain_ff == '0);
   assign status.word_full  = (fill_in == FillWidth'(BytesPerResult)) || (remain_in == '0);
   assign status.run_done   = (remain_ff == '0);
   assign status.out_busy   = ovalid_ff;

   assign rsp_valid      = ovalid_ff;
   assign rsp_out_bytes  = obytes_ff;
   assign rsp_byte_count = ocount_ff;
   assign rsp_last       = olast_ff;
endmodule

>>> hw/rtl/lz77_match_expander_top.sv
// a literal item goes through the read and emit states, then into the free output register
// a match passes a read state and a copy state per copied byte (window read then write),
//    plus an emit state per word, set by the registered window read feeding the next write
// emit waits while the output register still holds an earlier result
// reset: synchronous, active high; clears the write position and the controller,
//    window contents stay undefined until written
module lz77_match_expander_top #(
   parameter int unsigned WindowSize     = lzx_pkg::WindowSizeDefault,
   parameter int unsigned BytesPerResult = lzx_pkg::BytesPerResultDefault
) (
   input logic   clock,
   input logic   reset,
   lzx_stream_if.sink   req,
   lzx_stream_if.source rsp
);
   // request payload: distance, length, literal, kind (kind in bit 0)
   lzx_pkg::cmd_type    cmd;
   lzx_pkg::status_type status;

   logic                               req_kind;
   logic [7:0]                         req_literal;
   logic [lzx_pkg::LenWidth-1:0]       req_match_length;
   logic [lzx_pkg::DistWidth-1:0]      req_match_distance;
   logic [lzx_pkg::OutWidth-1:0]       rsp_out_bytes;
   logic [lzx_pkg::CountWidth-1:0]     rsp_byte_count;
   logic                               rsp_last;

   assign req_kind           = req.data[0];
   assign req_literal        = req.data[8:1];
   assign req_match_length   = req.data[17:9];
   assign req_match_distance = req.data[33:18];

   // response payload: last, count, bytes (bytes in low 64 bits)
   assign rsp.data = {rsp_last, rsp_byte_count, rsp_out_bytes};

   // sequencer: one item in flight
   lzx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window, pointers, word packer and output register
   lzx_datapath #(
      .WindowSize     (WindowSize),
      .BytesPerResult (BytesPerResult)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_kind),
      .req_literal        (req_literal),
      .req_match_length   (req_match_length),
      .req_match_distance (req_match_distance),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_out_bytes      (rsp_out_bytes),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_last           (rsp_last)
   );

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");

   // no new item while a run is in progress
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !cmd.copy && !cmd.emit)
      else $error("item accepted mid run");

   // byte count never zero or above the word size
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp_byte_count != '0 &&
                    rsp_byte_count <= lzx_pkg::CountWidth'(BytesPerResult))
      else $error("bad byte count");
endmodule

>>> tb/lz77_match_expander_top_tb.sv
module lz77_match_expander_top_tb;

   localparam int unsigned WinSize   = lzx_pkg::WindowSizeDefault;
   localparam int unsigned WordBytes = lzx_pkg::BytesPerResultDefault;
   localparam int unsigned StallLimit = 12000;   // cycles with no item moving on either side
   localparam int unsigned HoldCycles = 3000;    // long receiver hold-off
   localparam int unsigned RandItems  = 360;

   // token fields, packed onto the request channel with kind in bit 0
   typedef struct packed {
      logic                          kind;
      logic [7:0]                    lit;
      logic [lzx_pkg::LenWidth-1:0]  len;
      logic [lzx_pkg::DistWidth-1:0] distance;
   } token_type;

   // output word fields, bytes in the low bits of the response channel
   typedef struct packed {
      logic [lzx_pkg::OutWidth-1:0]   bytes;
      logic [lzx_pkg::CountWidth-1:0] count;
      logic                           last;
   } word_type;

   typedef struct {
      token_type tok;
      bit        typed;   // expected word written in below
      word_type  want;
   } row_type;

   logic clock;
   logic reset;

   lzx_stream_if #(.Width($bits(token_type))) req ();
   lzx_stream_if #(.Width($bits(word_type)))  rsp ();

   lz77_match_expander_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // predictor state: own copy of the history and write pointer
   logic [7:0]  window_copy [WinSize];
   logic [14:0] write_ptr;
   int unsigned bytes_seen;     // written bytes, saturates at the window size
   word_type    pending_words[$];

   int unsigned errors;
   int unsigned words_checked;
   int unsigned tokens_sent;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_left;
   bit          moved;          // an item crossed either channel this edge

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // work out the words one token produces, update the history copy
   function automatic void expand_token(token_type t);
      int unsigned n;
      int unsigned src;
      int unsigned fill;
      logic [63:0] acc;
      logic [7:0]  b;
      word_type    w;
      if (t.kind == lzx_pkg::KindLiteral) begin
         window_copy[write_ptr] = t.lit;
         write_ptr = write_ptr + 1'b1;
         if (bytes_seen < WinSize) bytes_seen++;
         w.bytes = {56'b0, t.lit};
         w.count = 4'd1;
         w.last  = 1'b1;
         pending_words.push_back(w);
         return;
      end
      n = t.len;
      if (n == 0) return;                 // empty match is dropped
      if (n > lzx_pkg::MaxMatchLength) n = lzx_pkg::MaxMatchLength;
      src  = (write_ptr + WinSize - (t.distance % WinSize)) % WinSize;
      fill = 0;
      acc  = '0;
      for (int unsigned i = 0; i < n; i++) begin
         b = window_copy[src];
         src = (src + 1) % WinSize;
         window_copy[write_ptr] = b;     // byte by byte, so overlap repeats
         write_ptr = write_ptr + 1'b1;
         if (bytes_seen < WinSize) bytes_seen++;
         acc[8*fill +: 8] = b;
         fill++;
         if (fill == WordBytes || i + 1 == n) begin
            w.bytes = acc;
            w.count = fill[lzx_pkg::CountWidth-1:0];
            w.last  = (i + 1 == n);
            pending_words.push_back(w);
            acc  = '0;
            fill = 0;
         end
      end
   endfunction

   // true when every byte the match reads has been written since reset
   function automatic bit reads_written(token_type t);
      int unsigned back;
      if (t.kind == lzx_pkg::KindLiteral || t.len == 0) return 1'b1;
      back = t.distance % WinSize;
      if (back == 0) back = WinSize;
      return back <= bytes_seen;
   endfunction

   // random token, mostly short matches close by, now and then the extremes
   function automatic token_type random_token();
      token_type t;
      int unsigned pick;
      t.kind = ($urandom_range(99) < 55) ? lzx_pkg::KindMatch : lzx_pkg::KindLiteral;
      t.lit  = 8'($urandom_range(255));
      pick   = $urandom_range(99);
      if (pick < 70)      t.len = lzx_pkg::LenWidth'($urandom_range(24, 1));
      else if (pick < 90) t.len = lzx_pkg::LenWidth'($urandom_range(383, 25));
      else if (pick < 95) t.len = lzx_pkg::LenWidth'($urandom_range(511, 384));  // saturates
      else                t.len = '0;
      pick = $urandom_range(99);
      if (pick < 60) t.distance = lzx_pkg::DistWidth'($urandom_range(16, 1));
      else           t.distance = lzx_pkg::DistWidth'($urandom_range(65535));
      if (!reads_written(t)) t.distance = lzx_pkg::DistWidth'($urandom_range(bytes_seen, 1));
      return t;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %0s: got %h want %h (word %0d)", what, got, want, words_checked);
      errors++;
   endtask

   // offer one token, wait for acceptance, then predict
   task automatic send_token(token_type t, bit typed = 1'b0, word_type want = '0);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= {t.distance, t.len, t.lit, t.kind};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expand_token(t);
      if (typed) begin
         void'(pending_words.pop_back());
         pending_words.push_back(want);
      end
      tokens_sent++;
   endtask

   // receiver: random stalls, long hold-off on request, checks each word
   initial begin
      word_type got;
      word_type want;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            got.bytes = rsp.data[lzx_pkg::OutWidth-1:0];
            got.count = rsp.data[lzx_pkg::OutWidth +: lzx_pkg::CountWidth];
            got.last  = rsp.data[lzx_pkg::OutWidth + lzx_pkg::CountWidth];
            if (pending_words.size() == 0) begin
               report_mismatch("unexpected word", got.bytes, '0);
            end else begin
               want = pending_words.pop_front();
               if (got.bytes !== want.bytes) report_mismatch("bytes", got.bytes, want.bytes);
               if (got.count !== want.count) report_mismatch("count", got.count, want.count);
               if (got.last !== want.last)   report_mismatch("last", got.last, want.last);
            end
            words_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no progress
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         moved = (req.valid && req.ready) || (rsp.valid && rsp.ready);
         if (moved || reset) quiet = 0;
         else quiet++;
      end
      $display("timeout: no item moved for %0d cycles", StallLimit);
      $display("FAIL");
      $finish;
   end

   initial begin
      row_type     rows[$];
      row_type     r;
      token_type   t;
      int unsigned drained;

      errors = 0;
      words_checked = 0;
      tokens_sent = 0;
      hold_left = 0;
      bytes_seen = 0;
      write_ptr = '0;
      foreach (window_copy[i]) window_copy[i] = 8'h00;

      // first phase: sender idles a quarter of the time, receiver over half
      send_idle_pct  = 24;
      recv_stall_pct = 55;
      reset     <= 1'b1;
      req.valid <= 1'b0;
      req.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows: literals carry their expected word, matches use the predictor
      rows = '{
         '{'{lzx_pkg::KindLiteral, 8'h00, 9'd0,   16'd0},     1, '{64'h00, 4'd1, 1'b1}},
         '{'{lzx_pkg::KindLiteral, 8'hff, 9'd0,   16'd0},     1, '{64'hff, 4'd1, 1'b1}},
         '{'{lzx_pkg::KindLiteral, 8'ha5, 9'd511, 16'hffff},  1, '{64'ha5, 4'd1, 1'b1}},
         '{'{lzx_pkg::KindLiteral, 8'h5a, 9'h155, 16'haaaa},  1, '{64'h5a, 4'd1, 1'b1}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd1,   16'd1},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'hff, 9'd0,   16'd0},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd0,   16'hffff},  0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h3c, 9'd9,   16'd1},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd16,  16'd4},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd8,   16'd8},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd7,   16'd5},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindLiteral, 8'h01, 9'd0,   16'd0},     1, '{64'h01, 4'd1, 1'b1}},
         '{'{lzx_pkg::KindLiteral, 8'h80, 9'd1,   16'd1},     1, '{64'h80, 4'd1, 1'b1}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd383, 16'd2},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd511, 16'd3},     0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd384, 16'd40},    0, '{64'h0,  4'd0, 1'b0}},
         '{'{lzx_pkg::KindMatch,   8'h00, 9'd2,   16'd100},   0, '{64'h0,  4'd0, 1'b0}}
      };
      foreach (rows[i]) begin
         r = rows[i];
         send_token(r.tok, r.typed, r.want);
      end

      // long hold-off while tokens keep coming, so the block backs up
      hold_left = HoldCycles;

      // fill the whole window with long matches, so any distance becomes legal
      while (bytes_seen < WinSize) begin
         t.kind     = lzx_pkg::KindMatch;
         t.lit      = 8'($urandom_range(255));
         t.len      = lzx_pkg::LenWidth'(lzx_pkg::MaxMatchLength);
         t.distance = lzx_pkg::DistWidth'($urandom_range(bytes_seen < 4096 ? bytes_seen : 4096,
                                                         1));
         send_token(t);
      end

      for (int unsigned i = 0; i < RandItems; i++) begin
         if (i == RandItems / 3) begin
            send_idle_pct  = 55;
            recv_stall_pct = 24;
         end else if (i == 2 * RandItems / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         send_token(random_token());
      end
      req.valid <= 1'b0;

      // drain, then run on for stray words
      drained = 0;
      while (pending_words.size() != 0 && drained < 200000) begin
         @(posedge clock);
         drained++;
      end
      repeat (100) @(posedge clock);

      $display("ran %0d tokens (literals, overlapping and saturated matches, full-window",
               tokens_sent);
      $display("distances) and checked %0d output words, %0d mismatches", words_checked,
               errors + pending_words.size());
      if (errors == 0 && pending_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
